FILE: rtl/sbgr_pkg.sv
package sbgr_pkg;

  localparam int unsigned MaxSize = 64;
  localparam int unsigned RowW = 7;
  localparam int unsigned ColW = 8;
  localparam logic [6:0] SizeReset = 7'd32;
  localparam logic [0:0] RegGlyphSize = 1'b0;

  typedef logic signed [ColW:0] coord_t;

  typedef enum logic [4:0] {
    GA, GB, GC, GD, GE, GF, GG, GH, GI, GJ, GK, GL, GM,
    GN, GO, GP, GQ, GR, GS, GT, GU, GV, GX, GY, GZ, GNONE
  } glyph_e;

  typedef struct packed {
    glyph_e g;
    logic   row_ok;
    logic   known;
  } ctl_t;

  // ceil(2^20 / d) for the denominators in use
  function automatic int unsigned recip(input int unsigned d);
    begin
      case (d)
        1:       recip = 32'd1048576;
        2:       recip = 32'd524288;
        3:       recip = 32'd349526;
        4:       recip = 32'd262144;
        5:       recip = 32'd209716;
        6:       recip = 32'd174763;
        10:      recip = 32'd104858;
        20:      recip = 32'd52429;
        40:      recip = 32'd26215;
        default: recip = 32'd0;
      endcase
    end
  endfunction

  // floor(n*s/d) for s up to 127
  function automatic coord_t frac(input logic [6:0] s, input int unsigned n,
                                  input int unsigned d);
    int unsigned p;
    begin
      p = ((n * 32'(s)) * recip(d)) >> 20;
      frac = coord_t'(p);
    end
  endfunction

endpackage

FILE: rtl/sbgr_decode.sv
module sbgr_decode #(
  parameter int unsigned MaxSize = sbgr_pkg::MaxSize
) (
  input  logic [7:0]     char_code_i,
  input  logic [5:0]     row_index_i,
  input  logic [6:0]     size_i,
  output sbgr_pkg::ctl_t ctl_o
);
  import sbgr_pkg::*;

  logic [7:0] ch;
  logic [6:0] s;

  always_comb begin
    ch = char_code_i;
    if (ch >= 8'h61 && ch <= 8'h7a) ch = ch - 8'h20;
    if (ch == 8'h30) ch = 8'h4f;
    s = (size_i > 7'(MaxSize)) ? 7'(MaxSize) : size_i;
    ctl_o.known = (ch >= 8'h41 && ch <= 8'h5a && ch != 8'h57);
    ctl_o.row_ok = {1'b0, row_index_i} < s;
    if (!ctl_o.known) begin
      ctl_o.g = GNONE;
    end else if (ch < 8'h57) begin
      ctl_o.g = glyph_e'(5'(ch - 8'h41));
    end else begin
      ctl_o.g = glyph_e'(5'(ch - 8'h42));
    end
  end

endmodule

FILE: rtl/sbgr_bounds.sv
module sbgr_bounds #(
  parameter int unsigned MaxSize = sbgr_pkg::MaxSize
) (
  input  logic [6:0]            size_i,
  output sbgr_pkg::coord_t      f_o [0:31]
);
  import sbgr_pkg::*;

  logic [6:0] s;

  always_comb begin
    s = (size_i > 7'(MaxSize)) ? 7'(MaxSize) : size_i;
    f_o[0]  = frac(s, 1, 10);  f_o[1]  = frac(s, 9, 10);
    f_o[2]  = frac(s, 3, 5);   f_o[3]  = frac(s, 1, 6);
    f_o[4]  = frac(s, 2, 5);   f_o[5]  = frac(s, 11, 20);
    f_o[6]  = frac(s, 13, 20); f_o[7]  = frac(s, 1, 4);
    f_o[8]  = frac(s, 3, 4);   f_o[9]  = frac(s, 23, 40);
    f_o[10] = frac(s, 4, 5);   f_o[11] = frac(s, 1, 3);
    f_o[12] = frac(s, 17, 40); f_o[13] = frac(s, 1, 5);
    f_o[14] = frac(s, 1, 2);   f_o[15] = frac(s, 17, 20);
    f_o[16] = frac(s, 26, 40); f_o[17] = frac(s, 2, 3);
    f_o[18] = frac(s, 6, 10);  f_o[19] = frac(s, 3, 10);
    f_o[20] = frac(s, 7, 10);  f_o[21] = frac(s, 7, 40);
    f_o[22] = frac(s, 8, 10);  f_o[23] = frac(s, 5, 6);
    f_o[24] = frac(s, 1, 1);
    f_o[25] = coord_t'(s) - frac(s, 1, 4);
    f_o[26] = coord_t'(s) - frac(s, 1, 10);
    f_o[27] = coord_t'(s) - frac(s, 1, 5);
    f_o[28] = coord_t'(s) - frac(s, 1, 6);
    f_o[29] = frac(s, 4, 10);
    f_o[30] = '0;
    f_o[31] = '0;
  end

endmodule

FILE: rtl/sbgr_bars.sv
module sbgr_bars (
  input  sbgr_pkg::glyph_e g_i,
  input  logic [5:0]       r_i,
  input  sbgr_pkg::coord_t f_i [0:31],
  output sbgr_pkg::coord_t k0_o [0:5],
  output sbgr_pkg::coord_t k1_o [0:5],
  output sbgr_pkg::coord_t i0_o [0:5],
  output sbgr_pkg::coord_t i1_o [0:5],
  output logic [5:0]       en_o
);
  import sbgr_pkg::*;

  coord_t r, h, s10, s90, s35, s6, s25, s4, s34, s5, s45, s3, s2, d, sm4, sm10, sm5;
  int n;

  always_comb begin
    r = coord_t'(r_i);
    h = coord_t'(r_i[5:1]);
    s10 = f_i[0]; s90 = f_i[1]; s35 = f_i[2]; s6 = f_i[3]; s25 = f_i[4];
    s4 = f_i[7]; s34 = f_i[8]; s5 = f_i[13]; s45 = f_i[10]; s3 = f_i[11];
    s2 = f_i[14]; d = f_i[21]; sm4 = f_i[25]; sm10 = f_i[26]; sm5 = f_i[27];
    for (n = 0; n < 6; n++) begin
      k0_o[n] = '0; k1_o[n] = '0; i0_o[n] = '0; i1_o[n] = '0;
    end
    en_o = '0;
    case (g_i)
      GA: begin
        en_o = 6'b000111;
        k0_o[0]=s10; k1_o[0]=s90; i0_o[0]=s35-h-s6+coord_t'(1); i1_o[0]=s35-h+coord_t'(1);
        k0_o[1]=s10; k1_o[1]=s90; i0_o[1]=s25+h; i1_o[1]=s25+h+s6;
        k0_o[2]=f_i[5]; k1_o[2]=f_i[6]; i0_o[2]=s4; i1_o[2]=s34;
      end
      GB, GP, GR: begin
        en_o = 6'b001111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s6; i1_o[0]=s3;
        k0_o[1]=s10; k1_o[1]=s4; i0_o[1]=s4; i1_o[1]=s35;
        k0_o[2]=f_i[12]; k1_o[2]=f_i[9]; i0_o[2]=s4; i1_o[2]=s35;
        k0_o[3]=s5; k1_o[3]=f_i[12]; i0_o[3]=s35; i1_o[3]=s34;
        if (g_i == GB) begin
          en_o = 6'b111111;
          k0_o[4]=sm4; k1_o[4]=sm10; i0_o[4]=s4; i1_o[4]=s35;
          k0_o[0]=f_i[9]; k1_o[0]=s45; i0_o[0]=s35; i1_o[0]=s34;
          k0_o[3]=s10; k1_o[3]=sm10; i0_o[3]=s6; i1_o[3]=s3;
          en_o = 6'b111111;
          // swap back top-right bar into slot 1 pattern
          k0_o[1]=s5; k1_o[1]=f_i[12]; i0_o[1]=s35; i1_o[1]=s34;
          k0_o[2]=f_i[12]; k1_o[2]=f_i[9]; i0_o[2]=s4; i1_o[2]=s35;
          k0_o[5]=s10; k1_o[5]=s4; i0_o[5]=s4; i1_o[5]=s35;
        end
        if (g_i == GR) begin
          en_o = 6'b011111;
          k0_o[4]=s2; k1_o[4]=f_i[15]; i0_o[4]=r-s6; i1_o[4]=r+s10;
        end
      end
      GC: begin
        en_o = 6'b000111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s5; i1_o[0]=s25;
        k0_o[1]=sm4; k1_o[1]=sm10; i0_o[1]=s4; i1_o[1]=sm5;
        k0_o[2]=s10; k1_o[2]=s4; i0_o[2]=s4; i1_o[2]=sm5;
      end
      GD: begin
        en_o = 6'b001111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s6; i1_o[0]=s3;
        k0_o[1]=sm4; k1_o[1]=sm10; i0_o[1]=s4; i1_o[1]=s35;
        k0_o[2]=s10; k1_o[2]=s4; i0_o[2]=s4; i1_o[2]=s35;
        k0_o[3]=s5; k1_o[3]=s45; i0_o[3]=s35; i1_o[3]=s34;
      end
      GE, GF: begin
        en_o = (g_i == GE) ? 6'b001111 : 6'b000111;
        k0_o[0]=f_i[12]; k1_o[0]=f_i[9]; i0_o[0]=s2-s10; i1_o[0]=s2+s10;
        k0_o[1]=s10; k1_o[1]=s4; i0_o[1]=s4; i1_o[1]=sm5;
        k0_o[2]=s10; k1_o[2]=sm10; i0_o[2]=s4; i1_o[2]=s25;
        k0_o[3]=sm4; k1_o[3]=sm10; i0_o[3]=s4; i1_o[3]=sm5;
      end
      GG: begin
        en_o = 6'b011111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s5; i1_o[0]=s25;
        k0_o[1]=s2; k1_o[1]=f_i[16]; i0_o[1]=f_i[18]; i1_o[1]=s45;
        k0_o[2]=sm4; k1_o[2]=sm10; i0_o[2]=s4; i1_o[2]=sm5;
        k0_o[3]=s10; k1_o[3]=s4; i0_o[3]=s4; i1_o[3]=sm5;
        k0_o[4]=f_i[9]; k1_o[4]=s45; i0_o[4]=f_i[17]; i1_o[4]=s45;
      end
      GH: begin
        en_o = 6'b000111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s4; i1_o[0]=s25;
        k0_o[1]=s10; k1_o[1]=sm10; i0_o[1]=s35; i1_o[1]=s34;
        k0_o[2]=f_i[29]; k1_o[2]=f_i[18]; i0_o[2]=s4; i1_o[2]=s34;
      end
      GI: begin
        en_o = 6'b000111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s2-s10; i1_o[0]=s2+s10;
        k0_o[1]=s10; k1_o[1]=s4; i0_o[1]=s4; i1_o[1]=sm5;
        k0_o[2]=sm4; k1_o[2]=sm10; i0_o[2]=s4; i1_o[2]=sm5;
      end
      GJ: begin
        en_o = 6'b000111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s2-s10; i1_o[0]=s2+s10;
        k0_o[1]=s10; k1_o[1]=s4; i0_o[1]=s5; i1_o[1]=sm5;
        k0_o[2]=sm4; k1_o[2]=sm10; i0_o[2]=s5; i1_o[2]=f_i[18];
      end
      GK: begin
        en_o = 6'b000111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s4; i1_o[0]=s25;
        k0_o[1]=s10; k1_o[1]=s2; i0_o[1]=f_i[24]-r-s6; i1_o[1]=f_i[24]-r;
        k0_o[2]=s2; k1_o[2]=s90; i0_o[2]=r-s6; i1_o[2]=r;
      end
      GL: begin
        en_o = 6'b000011;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s4; i1_o[0]=s25;
        k0_o[1]=sm4; k1_o[1]=sm10; i0_o[1]=s4; i1_o[1]=sm5;
      end
      GM, GN, GX, GY, GV, GZ: begin
        en_o = 6'b000011;
        k0_o[0]=s10; k1_o[0]=s90; i0_o[0]=f_i[24]-r-s10; i1_o[0]=f_i[24]-r+s10;
        k0_o[1]=s10; k1_o[1]=s90; i0_o[1]=s10+r-d; i1_o[1]=f_i[19]+r-d;
        if (g_i == GM || g_i == GY) begin
          k1_o[0]=s2; k1_o[1]=s2;
        end
        if (g_i == GM) begin
          en_o = 6'b011111;
          k0_o[2]=s10; k1_o[2]=s90; i0_o[2]=s10; i1_o[2]=f_i[19];
          k0_o[3]=s10; k1_o[3]=s90; i0_o[3]=f_i[20]; i1_o[3]=s90;
          k0_o[4]=f_i[29]; k1_o[4]=f_i[18]; i0_o[4]=s2-s10; i1_o[4]=s2+s10;
        end
        if (g_i == GN) begin
          en_o = 6'b001110;
          k0_o[1]=s10; k1_o[1]=f_i[22]; i0_o[1]=s10+r-d; i1_o[1]=f_i[29]+r-d;
          k0_o[2]=s10; k1_o[2]=s90; i0_o[2]=s10; i1_o[2]=f_i[19];
          k0_o[3]=s10; k1_o[3]=s90; i0_o[3]=f_i[20]; i1_o[3]=s90;
        end
        if (g_i == GV) begin
          i0_o[0]=f_i[24]-h-s10; i1_o[0]=f_i[24]-h+s10;
          i0_o[1]=s10+h-d; i1_o[1]=f_i[19]+h-d;
        end
        if (g_i == GY) begin
          en_o = 6'b000111;
          k0_o[2]=s2; k1_o[2]=s90; i0_o[2]=f_i[29]; i1_o[2]=f_i[18];
        end
        if (g_i == GZ) begin
          en_o = 6'b000111;
          k0_o[1]=s10; k1_o[1]=s4; i0_o[1]=s10; i1_o[1]=sm5;
          k0_o[2]=sm4; k1_o[2]=sm10; i0_o[2]=s4; i1_o[2]=s90;
        end
      end
      GO, GU, GQ: begin
        en_o = (g_i == GU) ? 6'b000111 : 6'b001111;
        k0_o[0]=s10; k1_o[0]=sm10; i0_o[0]=s5; i1_o[0]=s25;
        k0_o[1]=s10; k1_o[1]=sm10; i0_o[1]=s35; i1_o[1]=s45;
        k0_o[2]=sm4; k1_o[2]=sm10; i0_o[2]=s4; i1_o[2]=sm5;
        k0_o[3]=s10; k1_o[3]=s3; i0_o[3]=s4; i1_o[3]=sm5;
        if (g_i == GQ) begin
          en_o = 6'b011111;
          k0_o[4]=s34; k1_o[4]=f_i[24]; i0_o[4]=r-s6; i1_o[4]=r+s10;
        end
      end
      GS: begin
        en_o = 6'b011111;
        k0_o[0]=s5; k1_o[0]=f_i[9]; i0_o[0]=s6; i1_o[0]=s3;
        k0_o[1]=sm4; k1_o[1]=sm10; i0_o[1]=s6; i1_o[1]=f_i[23];
        k0_o[2]=s10; k1_o[2]=s4; i0_o[2]=s6; i1_o[2]=f_i[23];
        k0_o[3]=f_i[12]; k1_o[3]=f_i[9]; i0_o[3]=s3; i1_o[3]=f_i[17];
        k0_o[4]=f_i[12]; k1_o[4]=s45; i0_o[4]=f_i[17]; i1_o[4]=f_i[23];
      end
      GT: begin
        en_o = 6'b000011;
        k0_o[0]=s10; k1_o[0]=s3; i0_o[0]=s10; i1_o[0]=sm10;
        k0_o[1]=s10; k1_o[1]=sm10; i0_o[1]=s2-s10; i1_o[1]=s2+s10;
      end
      default: en_o = '0;
    endcase
  end

endmodule

FILE: rtl/sbgr_mask.sv
module sbgr_mask #(
  parameter int unsigned MaxSize = sbgr_pkg::MaxSize
) (
  input  logic [5:0]         r_i,
  input  logic [6:0]         size_i,
  input  sbgr_pkg::coord_t   k0_i,
  input  sbgr_pkg::coord_t   k1_i,
  input  sbgr_pkg::coord_t   i0_i,
  input  sbgr_pkg::coord_t   i1_i,
  input  logic               en_i,
  output logic [MaxSize-1:0] mask_o
);
  import sbgr_pkg::*;

  coord_t r, s, lo, hi;
  int c;

  always_comb begin
    r = coord_t'(r_i);
    s = (size_i > 7'(MaxSize)) ? coord_t'(MaxSize) : coord_t'(size_i);
    lo = (i0_i < 0) ? '0 : i0_i;
    hi = (i1_i > s) ? s : i1_i;
    for (c = 0; c < MaxSize; c++) begin
      mask_o[c] = en_i && (r >= k0_i) && (r < k1_i) &&
                  (coord_t'(c) >= lo) && (coord_t'(c) < hi);
    end
  end

endmodule

FILE: rtl/scalable_block_glyph_row_raster_core.sv
// glyph row rasterizer: one row of a block-letter glyph per transfer
// input channel: in_valid_i / in_stall_o with char_code_i and row_index_i
// output channel: out_valid_o / out_stall_i with row_bits_o and glyph_known_o
// bit c of row_bits_o is set when column c of the row is inked
// configuration: APB register 0 (glyph_size) at byte address 0, reset 32
// sizes above MAX_SIZE act as MAX_SIZE; rows at or beyond the size are empty
// 3 register stages; out_valid_o is driven by the valid bit of the third stage
// throughput: one row per cycle unless stalled; stage 1 decodes and looks up
// bar bounds, stage 2 selects the bar set, stage 3 rasterizes the bars into a mask
// the pipeline advances when the output register is empty or being taken;
// an output stall with out_valid_o high holds every stage and raises in_stall_o
// reset empties all stages and restores glyph_size to 32
// change glyph_size only while the pipeline is empty
module scalable_block_glyph_row_raster_core #(
  parameter int unsigned MaxSize = sbgr_pkg::MaxSize
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         char_code_i,
  input  logic [5:0]         row_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MaxSize-1:0] row_bits_o,
  output logic               glyph_known_o
);
  import sbgr_pkg::*;

  logic [6:0] size_q;
  logic       adv;
  logic       v1_q, v2_q, v3_q;
  ctl_t       ctl_d, c1_q, c2_q;
  logic [5:0] r1_q, r2_q;
  coord_t     f_d [0:31];
  coord_t     f1_q [0:31];
  coord_t     k0_d [0:5], k1_d [0:5], i0_d [0:5], i1_d [0:5];
  coord_t     k0_q [0:5], k1_q [0:5], i0_q [0:5], i1_q [0:5];
  logic [5:0] en_d, en_q;
  logic [MaxSize-1:0] m [0:5];
  logic [MaxSize-1:0] row_d, row_q;
  logic       known_q;

  assign pready = 1'b1;
  assign prdata = {25'd0, size_q};
  assign adv = !v3_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (psel && penable && pwrite && paddr == RegGlyphSize) begin
      size_q <= pwdata[6:0];
    end
  end

  sbgr_decode #(.MaxSize(MaxSize)) u_dec (
    .char_code_i(char_code_i), .row_index_i(row_index_i), .size_i(size_q), .ctl_o(ctl_d)
  );
  sbgr_bounds #(.MaxSize(MaxSize)) u_bnd (.size_i(size_q), .f_o(f_d));
  sbgr_bars u_bars (
    .g_i(c1_q.g), .r_i(r1_q), .f_i(f1_q),
    .k0_o(k0_d), .k1_o(k1_d), .i0_o(i0_d), .i1_o(i1_d), .en_o(en_d)
  );

  for (genvar b = 0; b < 6; b++) begin : g_bar
    sbgr_mask #(.MaxSize(MaxSize)) u_mask (
      .r_i(r2_q), .size_i(size_q), .k0_i(k0_q[b]), .k1_i(k1_q[b]),
      .i0_i(i0_q[b]), .i1_i(i1_q[b]), .en_i(en_q[b]), .mask_o(m[b])
    );
  end

  always_comb begin
    row_d = m[0] | m[1] | m[2] | m[3] | m[4] | m[5];
    if (!c2_q.known || !c2_q.row_ok) row_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= ctl_d;
      r1_q <= row_index_i;
      f1_q <= f_d;
      c2_q <= c1_q;
      r2_q <= r1_q;
      k0_q <= k0_d;
      k1_q <= k1_d;
      i0_q <= i0_d;
      i1_q <= i1_d;
      en_q <= en_d;
      row_q <= row_d;
      known_q <= c2_q.known;
    end
  end

  assign out_valid_o = v3_q;
  assign row_bits_o = row_q;
  assign glyph_known_o = known_q;

endmodule

FILE: dv/sbgr_row_checker.sv
`timescale 1ns / 1ps

module sbgr_row_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  row_index_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [63:0] row_bits_o,
  input  logic        glyph_known_o,
  output int          mismatch_cnt_o,
  output int          rows_pending_o
);
  import sbgr_pkg::*;

  typedef struct packed {
    logic [63:0] bits;
    logic        known;
  } row_t;

  row_t        row_q[$];
  logic [6:0]  size_q;

  function automatic logic [63:0] ink(int s, int r, int k0, int k1, int i0, int i1);
    logic [63:0] m;
    m = '0;
    if (r < k0 || r >= k1) return m;
    if (i0 < 0) i0 = 0;
    if (i1 > s) i1 = s;
    for (int i = i0; i < i1; i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic glyph_e decode(int c);
    if (c >= "a" && c <= "z") c = c - 32;
    if (c == "0") c = "O";
    if (c < "A" || c > "Z" || c == "W") return GNONE;
    if (c < "W") return glyph_e'(c - "A");
    return glyph_e'(c - "A" - 1);
  endfunction

  function automatic logic [63:0] raster(int s, int r, glyph_e g);
    logic [63:0] a;
    int d;
    a = '0;
    d = 7 * s / 40;
    if (g == GB) begin
      a |= ink(s, r, s - s/4, s - s/10, s/4, 3*s/5);
      a |= ink(s, r, 23*s/40, 4*s/5, 3*s/5, 3*s/4);
    end
    if (g == GE) a |= ink(s, r, s - s/4, s - s/10, s/4, s - s/5);
    if (g == GO) a |= ink(s, r, s/10, s/3, s/4, s - s/5);
    case (g)
      GA: begin
        a |= ink(s, r, s/10, 9*s/10, 3*s/5 - r/2 - s/6 + 1, 3*s/5 - r/2 + 1);
        a |= ink(s, r, s/10, 9*s/10, 2*s/5 + r/2, 2*s/5 + r/2 + s/6);
        a |= ink(s, r, 11*s/20, 13*s/20, s/4, 3*s/4);
      end
      GB, GP, GR: begin
        a |= ink(s, r, s/10, s - s/10, s/6, s/3);
        a |= ink(s, r, s/10, s/4, s/4, 3*s/5);
        a |= ink(s, r, 17*s/40, 23*s/40, s/4, 3*s/5);
        a |= ink(s, r, s/5, 17*s/40, 3*s/5, 3*s/4);
        if (g == GR) a |= ink(s, r, s/2, 17*s/20, r - s/6, r + s/10);
      end
      GC: begin
        a |= ink(s, r, s/10, s - s/10, s/5, 2*s/5);
        a |= ink(s, r, s - s/4, s - s/10, s/4, s - s/5);
        a |= ink(s, r, s/10, s/4, s/4, s - s/5);
      end
      GD: begin
        a |= ink(s, r, s/10, s - s/10, s/6, s/3);
        a |= ink(s, r, s - s/4, s - s/10, s/4, 3*s/5);
        a |= ink(s, r, s/10, s/4, s/4, 3*s/5);
        a |= ink(s, r, s/5, 4*s/5, 3*s/5, 3*s/4);
      end
      GE, GF: begin
        a |= ink(s, r, 17*s/40, 23*s/40, s/2 - s/10, s/2 + s/10);
        a |= ink(s, r, s/10, s/4, s/4, s - s/5);
        a |= ink(s, r, s/10, s - s/10, s/4, 2*s/5);
      end
      GG: begin
        a |= ink(s, r, s/10, s - s/10, s/5, 2*s/5);
        a |= ink(s, r, 20*s/40, 26*s/40, 6*s/10, 4*s/5);
        a |= ink(s, r, s - s/4, s - s/10, s/4, s - s/5);
        a |= ink(s, r, s/10, s/4, s/4, s - s/5);
        a |= ink(s, r, 23*s/40, 4*s/5, 2*s/3, 4*s/5);
      end
      GH: begin
        a |= ink(s, r, s/10, s - s/10, s/4, 2*s/5);
        a |= ink(s, r, s/10, s - s/10, 3*s/5, 3*s/4);
        a |= ink(s, r, 4*s/10, 6*s/10, s/4, 3*s/4);
      end
      GI: begin
        a |= ink(s, r, s/10, s - s/10, s/2 - s/10, s/2 + s/10);
        a |= ink(s, r, s/10, s/4, s/4, s - s/5);
        a |= ink(s, r, s - s/4, s - s/10, s/4, s - s/5);
      end
      GJ: begin
        a |= ink(s, r, s/10, s - s/10, s/2 - s/10, s/2 + s/10);
        a |= ink(s, r, s/10, s/4, s/5, s - s/5);
        a |= ink(s, r, s - s/4, s - s/10, s/5, 6*s/10);
      end
      GK: begin
        a |= ink(s, r, s/10, s - s/10, s/4, 2*s/5);
        a |= ink(s, r, s/10, s/2, s - r - s/6, s - r);
        a |= ink(s, r, s/2, 9*s/10, r - s/6, r);
      end
      GL: begin
        a |= ink(s, r, s/10, s - s/10, s/4, 2*s/5);
        a |= ink(s, r, s - s/4, s - s/10, s/4, s - s/5);
      end
      GM: begin
        a |= ink(s, r, s/10, s/2, s - r - s/10, s - r + s/10);
        a |= ink(s, r, s/10, s/2, s/10 + r - d, 3*s/10 + r - d);
        a |= ink(s, r, s/10, 9*s/10, s/10, 3*s/10);
        a |= ink(s, r, s/10, 9*s/10, 7*s/10, 9*s/10);
        a |= ink(s, r, 4*s/10, 6*s/10, s/2 - s/10, s/2 + s/10);
      end
      GN: begin
        a |= ink(s, r, s/10, 8*s/10, s/10 + r - d, 4*s/10 + r - d);
        a |= ink(s, r, s/10, 9*s/10, s/10, 3*s/10);
        a |= ink(s, r, s/10, 9*s/10, 7*s/10, 9*s/10);
      end
      GO, GU, GQ: begin
        a |= ink(s, r, s/10, s - s/10, s/5, 2*s/5);
        a |= ink(s, r, s/10, s - s/10, 3*s/5, 4*s/5);
        a |= ink(s, r, s - s/4, s - s/10, s/4, s - s/5);
        if (g == GQ) begin
          a |= ink(s, r, s/10, s/3, s/4, s - s/5);
          a |= ink(s, r, 3*s/4, s, r - s/6, r + s/10);
        end
      end
      GS: begin
        a |= ink(s, r, 2*s/10, 23*s/40, s/6, s/3);
        a |= ink(s, r, s - s/4, s - s/10, s/6, 5*s/6);
        a |= ink(s, r, s/10, s/4, s/6, 5*s/6);
        a |= ink(s, r, 17*s/40, 23*s/40, s/3, 2*s/3);
        a |= ink(s, r, 17*s/40, 4*s/5, 2*s/3, 5*s/6);
      end
      GT: begin
        a |= ink(s, r, s/10, s/3, s/10, s - s/10);
        a |= ink(s, r, s/10, s - s/10, s/2 - s/10, s/2 + s/10);
      end
      GV: begin
        a |= ink(s, r, s/10, 9*s/10, s - r/2 - s/10, s - r/2 + s/10);
        a |= ink(s, r, s/10, 9*s/10, s/10 + r/2 - d, 3*s/10 + r/2 - d);
      end
      GX, GY, GZ: begin
        a |= ink(s, r, s/10, (g == GY) ? s/2 : 9*s/10, s - r - s/10, s - r + s/10);
        if (g != GZ) a |= ink(s, r, s/10, (g == GY) ? s/2 : 9*s/10,
                              s/10 + r - d, 3*s/10 + r - d);
        if (g == GY) a |= ink(s, r, s/2, 9*s/10, 4*s/10, 6*s/10);
        if (g == GZ) begin
          a |= ink(s, r, s/10, s/4, s/10, s - s/5);
          a |= ink(s, r, s - s/4, s - s/10, s/4, 9*s/10);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic row_t predict_row(logic [7:0] c, logic [5:0] r, logic [6:0] sz);
    row_t p;
    int s;
    glyph_e g;
    s = (sz > MaxSize) ? MaxSize : int'(sz);
    g = decode(int'(c));
    p.known = (g != GNONE);
    p.bits = (p.known && int'(r) < s) ? raster(s, int'(r), g) : '0;
    return p;
  endfunction

  assign rows_pending_o = row_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      mismatch_cnt_o <= 0;
      row_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegGlyphSize)
        size_q <= pwdata[6:0];
      if (out_valid_o && !out_stall_i) begin
        if (row_q.size() == 0) begin
          mismatch_cnt_o <= mismatch_cnt_o + 1;
          if (mismatch_cnt_o < 10)
            $display("unexpected transfer: bits=%h known=%b", row_bits_o, glyph_known_o);
        end else begin
          row_t e;
          e = row_q.pop_front();
          if (e.bits !== row_bits_o || e.known !== glyph_known_o) begin
            mismatch_cnt_o <= mismatch_cnt_o + 1;
            if (mismatch_cnt_o < 10)
              $display("mismatch: expected bits=%h known=%b, got bits=%h known=%b",
                       e.bits, e.known, row_bits_o, glyph_known_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o)
        row_q.push_back(predict_row(char_code_i, row_index_i, size_q));
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sbgr_pkg::*;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  logic [7:0]  char_code_i;
  logic [5:0]  row_index_i;
  logic        out_valid_o, out_stall_i;
  logic [63:0] row_bits_o;
  logic        glyph_known_o;
  int          mismatch_cnt, rows_pending;
  logic        hold_long, no_idle;
  int          cur_size;

  scalable_block_glyph_row_raster_core dut (.*);

  sbgr_row_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .char_code_i, .row_index_i,
    .out_valid_o, .out_stall_i, .row_bits_o, .glyph_known_o,
    .mismatch_cnt_o(mismatch_cnt), .rows_pending_o(rows_pending)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  initial begin
    #5ms;
    $display("scalable_block_glyph_row_raster_core test failed");
    $finish;
  end

  task automatic drain();
    while (rows_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [6:0] v);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= RegGlyphSize;
    pwdata <= {$urandom_range(0, 1) ? $urandom() : 32'h0} & 32'hffff_ff80 | 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    cur_size = (v > MaxSize) ? MaxSize : int'(v);
  endtask

  // one transfer on the input channel
  task automatic send(logic [7:0] c, logic [5:0] r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1; char_code_i <= c; row_index_i <= r;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 8'(65 + $urandom_range(0, 25));
    if (k < 75) return 8'(97 + $urandom_range(0, 25));
    if (k < 80) return "0";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [5:0] pick_row();
    if (cur_size == 0 || $urandom_range(0, 3) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, cur_size - 1));
  endfunction

  // receiver side
  initial begin
    int n;
    out_stall_i <= 1'b1;
    @(posedge rst_ni);
    forever begin
      n = hold_long ? 300 : (no_idle ? 0 : $urandom_range(0, 10));
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [7:0] dir_chars[12];
    logic [6:0] sizes[12];
    dir_chars = '{"0", "W", "w", "a", "z", "A", "Z", 8'h00, 8'hff, "@", "[", "{"};
    sizes = '{7'd10, 7'd64, 7'd0, 7'd5, 7'd127, 7'd65, 7'd9, 7'd33, 7'd11, 7'd17, 7'd48,
              7'd32};
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0; char_code_i <= '0; row_index_i <= '0;
    hold_long = 1'b0; no_idle = 1'b0; cur_size = 32;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 12; i++) send(dir_chars[i], (i % 3 == 0) ? 6'd0 : 6'd16);
    send("M", 6'd31); send("Q", 6'd32); send("K", 6'd63); send("x", 6'd20);
    in_valid_i <= 1'b0;

    for (int p = 0; p < 12; p++) begin
      reg_write((p == 11) ? 7'($urandom_range(10, 64)) : sizes[p]);
      for (int i = 0; i < 135; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
        if (p == 2 && i == 20) hold_long = 1'b1;
        if (p == 2 && i == 40) hold_long = 1'b0;
        if (i == 70) begin
          in_valid_i <= 1'b0;
          while (rows_pending != 0) @(posedge clk_i);
        end
        send(pick_char(), pick_row());
      end
      in_valid_i <= 1'b0;
    end
    no_idle = 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && rows_pending == 0)
      $display("scalable_block_glyph_row_raster_core test passed");
    else
      $display("scalable_block_glyph_row_raster_core test failed");
    $finish;
  end

endmodule
